/* rtl/gnss_arc_segment_tracker_macros.svh */
// Assertion helpers for the tracker RTL.
`ifndef GNSS_ARC_SEGMENT_TRACKER_MACROS_SVH
`define GNSS_ARC_SEGMENT_TRACKER_MACROS_SVH

// Check a property at every clock edge outside reset.
`define GAST_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define GAST_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gast_pkg.sv */
package gast_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int LENGTH_BITS = 20;

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int LEN_W     = LENGTH_BITS;
    localparam int KEY_W     = 8;
    localparam int MAP_DEPTH = 1 << KEY_W;
    localparam int TIME_W    = 30;
    localparam int CFG_W     = 11;
    localparam int GAP_W     = 27;
    localparam int OUT_SLOT_W = 6;
    localparam int OUT_LEN_W  = 20;
    localparam int EXT_W      = (LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W;

    localparam int unsigned GALILEO_OFFSET = 150;
    localparam int unsigned MS_PER_MIN     = 60000;
    localparam logic [CFG_W-1:0]     GAP_MIN_RESET = CFG_W'(1);
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX   = '1;

    typedef enum logic {
        OP_OBS   = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_SKIP   = 3'd0,
        ST_NEW    = 3'd1,
        ST_APPEND = 3'd2,
        ST_SLIP   = 3'd3,
        ST_GAP    = 3'd4,
        ST_FULL   = 3'd5,
        ST_FLUSH  = 3'd6,
        ST_EMPTY  = 3'd7
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic              constellation;
        logic [5:0]        prn;
        logic [TIME_W-1:0] time_ms;
        logic              phase_valid;
        logic              slip;
    } t_in;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     satellite_key;
        logic [OUT_SLOT_W-1:0] slot;
        logic [OUT_LEN_W-1:0] closed_length;
        logic                 arc_kept;
        logic                 last;
    } t_out;

    // One slot's arc record, as it travels around the ring of cells.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_time;
        logic [LEN_W-1:0]  length;
    } t_rec;

    // Clamp an arc length to the width of the result field.
    function automatic logic [OUT_LEN_W-1:0] f_out_len(input logic [LEN_W-1:0] len);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(len);
        if (ext > EXT_W'(OUT_LEN_MAX)) begin
            f_out_len = OUT_LEN_MAX;
        end else begin
            f_out_len = OUT_LEN_W'(ext);
        end
    endfunction

endpackage

/* rtl/gnss_arc_segment_tracker.sv */
// Sequencing: a skipped or table-full observation is answered from the lookup state and an
// empty flush from the flush state, into the output register; any other observation waits in
// the seek state until the ring of slot cells rotates the satellite's record to its head.
// Throughput: one item at a time; a flush of n arcs emits one beat per cycle while the output
// is ready, once slot 0 reaches the head; a stalled beat waits until its slot comes round again.
// Reset (i_rst_n low, synchronous): table empty, gap limit 1 minute, no result pending.
module gnss_arc_segment_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gast_pkg::t_in                 i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gast_pkg::t_out                o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gast_pkg::CFG_W-1:0]    i_cfg_data
);

    // Slot records circulate through NUM_SLOTS cells, one position per cycle.
    // Slot k sits at the ring head whenever the control's position counter reads k,
    // so each record is read and rewritten there in a single pass.
    gast_pkg::t_rec w_ring [gast_pkg::NUM_SLOTS];
    gast_pkg::t_rec w_feed;

    generate
        for (genvar k = 0; k < gast_pkg::NUM_SLOTS; k++) begin : g_ring
            if (k == 0) begin : g_first
                gast_cell u_cell (
                    .i_clk (i_clk),
                    .i_rec (w_feed),
                    .o_rec (w_ring[k])
                );
            end else begin : g_next
                gast_cell u_cell (
                    .i_clk (i_clk),
                    .i_rec (w_ring[k-1]),
                    .o_rec (w_ring[k])
                );
            end
        end
    endgenerate

    // Control: key lookup, per-item sequencing, arc update at the ring head,
    // output register and the gap limit register.
    gast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_ring[gast_pkg::NUM_SLOTS-1]),
        .o_feed      (w_feed)
    );

endmodule

/* rtl/gast_cell.sv */
// One ring position: register a slot record and hand it to the next cell.
module gast_cell (
    input  logic            i_clk,
    input  gast_pkg::t_rec  i_rec,
    output gast_pkg::t_rec  o_rec
);

    gast_pkg::t_rec r_rec;

    always_ff @(posedge i_clk) begin
        r_rec <= i_rec;
    end

    assign o_rec = r_rec;

endmodule

/* rtl/gast_ctrl.sv */
`include "gnss_arc_segment_tracker_macros.svh"

module gast_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gast_pkg::t_in                 i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gast_pkg::t_out                o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gast_pkg::CFG_W-1:0]    i_cfg_data,
    input  gast_pkg::t_rec                i_head,
    output gast_pkg::t_rec                o_feed
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEEK,
        S_FLUSH
    } t_state;

    t_state                          r_state, n_state;
    gast_pkg::t_in                   r_item, n_item;
    logic [gast_pkg::KEY_W-1:0]      r_key, n_key;
    logic [gast_pkg::CNT_W-1:0]      r_used, n_used;
    logic [gast_pkg::SLOT_W-1:0]     r_target, n_target;
    logic                            r_is_new, n_is_new;
    logic [gast_pkg::SLOT_W-1:0]     r_pos, n_pos;
    logic [gast_pkg::GAP_W-1:0]      r_gap_ms, n_gap_ms;
    logic                            r_out_valid, n_out_valid;
    gast_pkg::t_out                  r_out, n_out;

    // Key to slot map: slot numbers in a memory, valid bits in flops.
    logic [gast_pkg::SLOT_W-1:0]     mem_slot [gast_pkg::MAP_DEPTH];
    logic [gast_pkg::MAP_DEPTH-1:0]  r_map_valid;
    logic [gast_pkg::SLOT_W-1:0]     r_map_slot;
    logic                            r_map_hit;

    logic [gast_pkg::KEY_W-1:0]      w_in_key;
    logic [gast_pkg::KEY_W-1:0]      w_rd_key;
    logic                            w_out_free;
    logic                            w_map_we;
    logic                            w_clear;
    logic                            w_emit;
    gast_pkg::t_out                  w_out;
    logic                            w_at_target;
    logic                            w_full;
    logic                            w_last;
    logic [gast_pkg::TIME_W:0]       w_diff;
    logic                            w_gap;
    logic                            w_kept;
    logic [gast_pkg::LEN_W-1:0]      w_len_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_in_key = gast_pkg::KEY_W'(i_in_item.prn)
                    + (i_in_item.constellation ? gast_pkg::KEY_W'(gast_pkg::GALILEO_OFFSET)
                                               : gast_pkg::KEY_W'(0));
    assign w_rd_key   = (r_state == S_IDLE) ? w_in_key : r_key;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_at_target = (r_pos == r_target);
    assign w_full      = (r_used >= gast_pkg::CNT_W'(gast_pkg::NUM_SLOTS));
    assign w_last      = ((gast_pkg::CNT_W'(r_target) + 1'b1) == r_used);

    // Arc checks on the record now leaving the ring.
    assign w_diff = {1'b0, r_item.time_ms} - {1'b0, i_head.last_time};
    assign w_gap  = !w_diff[gast_pkg::TIME_W]
                  && (w_diff[gast_pkg::TIME_W-1:0] > gast_pkg::TIME_W'(r_gap_ms));
    assign w_kept = (i_head.length > gast_pkg::LEN_W'(1));
    assign w_len_inc = (i_head.length == '1) ? i_head.length
                                             : i_head.length + 1'b1;

    assign n_pos = (r_pos == gast_pkg::SLOT_W'(gast_pkg::NUM_SLOTS - 1))
                 ? '0 : r_pos + 1'b1;

    assign n_gap_ms = i_cfg_valid
                    ? gast_pkg::GAP_W'(i_cfg_data) * gast_pkg::GAP_W'(gast_pkg::MS_PER_MIN)
                    : r_gap_ms;

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_key    = r_key;
        n_used   = r_used;
        n_target = r_target;
        n_is_new = r_is_new;
        w_map_we = 1'b0;
        w_clear  = 1'b0;
        w_emit   = 1'b0;
        w_out    = '0;
        o_feed   = i_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_key  = w_in_key;
                    if (i_in_item.operation == gast_pkg::OP_FLUSH) begin
                        n_target = '0;
                        n_state  = S_FLUSH;
                    end else begin
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                if (!r_item.phase_valid) begin
                    if (w_out_free) begin
                        w_emit              = 1'b1;
                        w_out.status        = gast_pkg::ST_SKIP;
                        w_out.satellite_key = r_key;
                        w_out.slot          = r_map_hit ? gast_pkg::OUT_SLOT_W'(r_map_slot)
                                                        : '0;
                        w_out.last          = 1'b1;
                        n_state             = S_IDLE;
                    end
                end else if (!r_map_hit) begin
                    if (w_full) begin
                        if (w_out_free) begin
                            w_emit              = 1'b1;
                            w_out.status        = gast_pkg::ST_FULL;
                            w_out.satellite_key = r_key;
                            w_out.last          = 1'b1;
                            n_state             = S_IDLE;
                        end
                    end else begin
                        n_target = gast_pkg::SLOT_W'(r_used);
                        n_is_new = 1'b1;
                        n_state  = S_SEEK;
                    end
                end else begin
                    n_target = r_map_slot;
                    n_is_new = 1'b0;
                    n_state  = S_SEEK;
                end
            end
            S_SEEK: begin
                if (w_at_target && w_out_free) begin
                    w_emit              = 1'b1;
                    w_out.satellite_key = r_key;
                    w_out.slot          = gast_pkg::OUT_SLOT_W'(r_target);
                    w_out.last          = 1'b1;
                    o_feed.key          = r_key;
                    o_feed.last_time    = r_item.time_ms;
                    o_feed.length       = gast_pkg::LEN_W'(1);
                    n_state             = S_IDLE;
                    if (r_is_new) begin
                        w_out.status = gast_pkg::ST_NEW;
                        w_map_we     = 1'b1;
                        n_used       = r_used + 1'b1;
                    end else if (r_item.slip || w_gap) begin
                        w_out.status        = r_item.slip ? gast_pkg::ST_SLIP
                                                          : gast_pkg::ST_GAP;
                        w_out.closed_length = gast_pkg::f_out_len(i_head.length);
                        w_out.arc_kept      = w_kept;
                    end else begin
                        w_out.status  = gast_pkg::ST_APPEND;
                        o_feed.length = w_len_inc;
                    end
                end
            end
            S_FLUSH: begin
                if (r_used == '0) begin
                    if (w_out_free) begin
                        w_emit       = 1'b1;
                        w_out.status = gast_pkg::ST_EMPTY;
                        w_out.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (w_at_target && w_out_free) begin
                    w_emit              = 1'b1;
                    w_out.status        = gast_pkg::ST_FLUSH;
                    w_out.satellite_key = i_head.key;
                    w_out.slot          = gast_pkg::OUT_SLOT_W'(r_target);
                    w_out.closed_length = gast_pkg::f_out_len(i_head.length);
                    w_out.arc_kept      = w_kept;
                    w_out.last          = w_last;
                    if (w_last) begin
                        w_clear = 1'b1;
                        n_used  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_target = r_target + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_free) begin
            n_out_valid = w_emit;
            if (w_emit) begin
                n_out = w_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pos       <= '0;
            r_gap_ms    <= gast_pkg::GAP_W'(gast_pkg::GAP_MIN_RESET)
                         * gast_pkg::GAP_W'(gast_pkg::MS_PER_MIN);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pos       <= n_pos;
            r_gap_ms    <= n_gap_ms;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_key    <= n_key;
        r_target <= n_target;
        r_is_new <= n_is_new;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            mem_slot[r_key] <= r_target;
        end
        r_map_slot <= mem_slot[w_rd_key];
    end

    always_ff @(posedge i_clk) begin
        r_map_hit <= r_map_valid[w_rd_key];
        if (!i_rst_n) begin
            r_map_valid <= '0;
        end else if (w_clear) begin
            r_map_valid <= '0;
        end else if (w_map_we) begin
            r_map_valid[r_key] <= 1'b1;
        end
    end

    `GAST_CHECK(a_used_bound, i_clk, i_rst_n, r_used <= gast_pkg::CNT_W'(gast_pkg::NUM_SLOTS), "slot count above capacity")
    `GAST_CHECK_NEXT(a_pos_step, i_clk, i_rst_n, 1'b1, r_pos == (($past(r_pos) == gast_pkg::SLOT_W'(gast_pkg::NUM_SLOTS - 1)) ? '0 : $past(r_pos) + 1'b1), "ring position lost step")
    `GAST_CHECK_NEXT(a_new_grows, i_clk, i_rst_n, w_emit && (w_out.status == gast_pkg::ST_NEW), r_used == $past(r_used) + 1'b1, "new satellite did not take a slot")
    `GAST_CHECK_NEXT(a_flush_empties, i_clk, i_rst_n, w_clear, (r_used == '0) && (r_state == S_IDLE) && (r_map_valid == '0), "flush left table in use")

endmodule

/* bench/gnss_arc_segment_tracker_tb.sv */
module gnss_arc_segment_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One satellite as the sender names it: constellation bit and prn.
    typedef struct packed {
        logic       cons;
        logic [5:0] prn;
    } t_sat;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    gast_pkg::t_in              in_item   = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [gast_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    gast_pkg::t_out             o_out_item;
    logic                       o_cfg_ready;

    // Set during the back-to-back stretch: neither side idles then.
    bit no_idle  = 1'b0;
    int failures = 0;

    // Arc table as the bench tracks it, mirrored from what the block must hold.
    bit                          key_mapped [gast_pkg::MAP_DEPTH];
    logic [5:0]                  key_slot   [gast_pkg::MAP_DEPTH];
    logic [gast_pkg::KEY_W-1:0]  arc_key    [gast_pkg::NUM_SLOTS];
    logic [gast_pkg::TIME_W-1:0] arc_time   [gast_pkg::NUM_SLOTS];
    logic [gast_pkg::LEN_W-1:0]  arc_len    [gast_pkg::NUM_SLOTS];
    int                          arcs_open = 0;
    logic [gast_pkg::CFG_W-1:0]  gap_limit_min = gast_pkg::GAP_MIN_RESET;

    // Result beats still owed by the block, oldest first.
    gast_pkg::t_out arc_reports[$];

    // Satellites in view for the random epochs, and the running epoch time.
    t_sat        sky[$];
    logic [29:0] sky_time = '0;

    gnss_arc_segment_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Stall the result side at random, about 17 percent of the time, unless no_idle is set.
    always @(posedge clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= 17);
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Append one owed report behind the others.
    function automatic void owe_report(input gast_pkg::t_out r);
        arc_reports.insert(arc_reports.size(), r);
    endfunction

    // Compare every accepted result beat with the oldest owed report.
    always @(posedge clk) begin
        gast_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (arc_reports.size() == 0) begin
                $error("result beat with none owed: status %0d key %0d slot %0d",
                       o_out_item.status, o_out_item.satellite_key, o_out_item.slot);
                failures++;
            end else begin
                want = arc_reports.pop_front();
                check_field("status", want.status, o_out_item.status);
                check_field("satellite_key", want.satellite_key, o_out_item.satellite_key);
                check_field("slot", want.slot, o_out_item.slot);
                check_field("closed_length", want.closed_length, o_out_item.closed_length);
                check_field("arc_kept", want.arc_kept, o_out_item.arc_kept);
                check_field("last", want.last, o_out_item.last);
            end
        end
    end

    // Work out the reports one request causes and advance the arc table.
    function automatic void track_arcs(input gast_pkg::t_in item);
        logic [gast_pkg::KEY_W-1:0] key;
        logic [5:0]                 slot;
        logic [gast_pkg::LEN_W-1:0] len;
        longint                     diff;
        gast_pkg::t_out             r;
        int                         n;
        r      = '0;
        r.last = 1'b1;
        if (item.operation == gast_pkg::OP_FLUSH) begin
            n = arcs_open;
            if (n == 0) begin
                r.status = gast_pkg::ST_EMPTY;
                owe_report(r);
                return;
            end
            // Walk the used slots in order; only the final one carries last.
            for (int i = 0; i < n; i++) begin
                r.status        = gast_pkg::ST_FLUSH;
                r.satellite_key = arc_key[i];
                r.slot          = 6'(i);
                r.closed_length = (arc_len[i] > gast_pkg::OUT_LEN_MAX)
                                ? gast_pkg::OUT_LEN_MAX
                                : gast_pkg::OUT_LEN_W'(arc_len[i]);
                r.arc_kept      = (arc_len[i] > 1);
                r.last          = (i == n - 1);
                owe_report(r);
            end
            foreach (key_mapped[k]) key_mapped[k] = 1'b0;
            arcs_open = 0;
            return;
        end
        // Galileo keys sit 150 above the GPS ones.
        key = gast_pkg::KEY_W'(item.prn + (item.constellation ? gast_pkg::GALILEO_OFFSET : 0));
        r.satellite_key = key;
        // Skip happens before any lookup, but still reports a known slot.
        if (!item.phase_valid) begin
            r.status = gast_pkg::ST_SKIP;
            r.slot   = key_mapped[key] ? key_slot[key] : '0;
            owe_report(r);
            return;
        end
        if (!key_mapped[key]) begin
            // Drop a new satellite once every slot is taken.
            if (arcs_open >= gast_pkg::NUM_SLOTS) begin
                r.status = gast_pkg::ST_FULL;
                owe_report(r);
                return;
            end
            slot = 6'(arcs_open);
            arcs_open++;
            key_mapped[key] = 1'b1;
            key_slot[key]   = slot;
            arc_key[slot]   = key;
            arc_time[slot]  = item.time_ms;
            arc_len[slot]   = gast_pkg::LEN_W'(1);
            r.status = gast_pkg::ST_NEW;
            r.slot   = slot;
            owe_report(r);
            return;
        end
        slot = key_slot[key];
        len  = arc_len[slot];
        // Signed difference: time running backward never counts as a gap.
        diff = longint'(item.time_ms) - longint'(arc_time[slot]);
        r.slot = slot;
        arc_time[slot] = item.time_ms;
        if (item.slip
            || diff > longint'(gap_limit_min) * longint'(gast_pkg::MS_PER_MIN)) begin
            // Slip wins over gap when both hold.
            r.status        = item.slip ? gast_pkg::ST_SLIP : gast_pkg::ST_GAP;
            r.closed_length = (len > gast_pkg::OUT_LEN_MAX) ? gast_pkg::OUT_LEN_MAX
                                                            : gast_pkg::OUT_LEN_W'(len);
            r.arc_kept      = (len > 1);
            arc_len[slot]   = gast_pkg::LEN_W'(1);
        end else begin
            r.status = gast_pkg::ST_APPEND;
            if (len != '1) arc_len[slot] = len + 1'b1;
        end
        owe_report(r);
    endfunction

    function automatic gast_pkg::t_in observation(input logic cons, input logic [5:0] prn,
                                                  input logic [29:0] t, input logic pv,
                                                  input logic slip);
        gast_pkg::t_in item;
        item.operation     = gast_pkg::OP_OBS;
        item.constellation = cons;
        item.prn           = prn;
        item.time_ms       = t;
        item.phase_valid   = pv;
        item.slip          = slip;
        return item;
    endfunction

    // Random bits everywhere, with the operation forced afterwards.
    function automatic gast_pkg::t_in junk_item(input gast_pkg::t_op op);
        logic [63:0]   bits;
        gast_pkg::t_in item;
        bits = {$urandom(), $urandom()};
        item = bits[$bits(gast_pkg::t_in)-1:0];
        item.operation = op;
        return item;
    endfunction

    // Send one request beat; valid is left high after acceptance so the next
    // call can hold it without a low pulse in between.
    task automatic send_item(input gast_pkg::t_in item);
        while (!no_idle && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        track_arcs(item);
        do @(posedge clk); while (!o_in_ready);
    endtask

    // Hold off the sender until every owed report has come back.
    task automatic settle;
        in_valid <= 1'b0;
        while (arc_reports.size() != 0) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_gap_limit(input logic [gast_pkg::CFG_W-1:0] minutes);
        cfg_valid <= 1'b1;
        cfg_data  <= minutes;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        gap_limit_min = minutes;
    endtask

    // A few epochs over a sky of satellites, with noise, slips and skips mixed
    // in; returns the number of phase-valid observations and flushes that it sends.
    task automatic run_sky_round(output int beats);
        int            nsat;
        int            epochs;
        int            roll;
        longint        gap_ms;
        logic [29:0]   step;
        t_sat          s;
        gast_pkg::t_in item;
        beats = 0;
        if (sky.size() == 0 || $urandom_range(1) == 1) begin
            sky.delete();
            // Now and then a crowded sky, which can overflow the table.
            nsat = ($urandom_range(99) < 5) ? $urandom_range(70, 40) : $urandom_range(12, 1);
            repeat (nsat) begin
                s.cons = 1'($urandom_range(1));
                s.prn  = 6'($urandom_range(63));
                sky.insert(sky.size(), s);
            end
        end
        if ($urandom_range(99) < 20) sky_time = 30'($urandom());
        epochs = (sky.size() > 20) ? 2 : $urandom_range(8, 2);
        gap_ms = longint'(gap_limit_min) * longint'(gast_pkg::MS_PER_MIN);
        repeat (epochs) begin
            roll = $urandom_range(99);
            if (roll < 70)      step = 30'd100;
            else if (roll < 80) step = 30'($urandom_range(60000, 1000));
            else if (roll < 88) step = 30'(gap_ms + $urandom_range(1));
            else if (roll < 95) step = 30'(gap_ms + $urandom_range(10_000_000, 1));
            else                step = 30'(32'd0 - $urandom_range(5000, 1));
            sky_time = sky_time + step;
            foreach (sky[i]) begin
                if ($urandom_range(99) < 8) begin
                    item = junk_item(gast_pkg::OP_OBS);
                end else begin
                    item = observation(sky[i].cons, sky[i].prn, sky_time,
                                       $urandom_range(99) >= 5, $urandom_range(99) < 6);
                end
                send_item(item);
                if (item.phase_valid) beats++;
            end
        end
        if ($urandom_range(99) < 30) begin
            send_item(junk_item(gast_pkg::OP_FLUSH));
            beats++;
        end
    endtask

    task automatic test_empty_flush;
        send_item(junk_item(gast_pkg::OP_FLUSH));
    endtask

    // New keys at both ends of both constellations, then every kind of
    // restart, skips, backward time and the top of the time field.
    task automatic test_arc_basics;
        logic [29:0] t0;
        t0 = 30'd1000;
        send_item(observation(1'b0, 6'd63, t0, 1'b1, 1'b0));
        send_item(observation(1'b1, 6'd63, t0, 1'b1, 1'b0));
        send_item(observation(1'b0, 6'd0, t0, 1'b1, 1'b0));
        send_item(observation(1'b1, 6'd0, t0, 1'b1, 1'b0));
        send_item(observation(1'b0, 6'd63, t0 + 100, 1'b1, 1'b0));
        // Skip on a known key, then on one never seen.
        send_item(observation(1'b0, 6'd63, t0 + 150, 1'b0, 1'b1));
        send_item(observation(1'b0, 6'd5, t0 + 150, 1'b0, 1'b0));
        // Slip closing a kept arc, then a single-epoch one.
        send_item(observation(1'b0, 6'd63, t0 + 200, 1'b1, 1'b1));
        send_item(observation(1'b0, 6'd0, t0 + 100, 1'b1, 1'b1));
        // Exactly at the limit appends, one past it restarts.
        send_item(observation(1'b1, 6'd63, t0 + 60000, 1'b1, 1'b0));
        send_item(observation(1'b1, 6'd63, t0 + 120001, 1'b1, 1'b0));
        // Slip together with a gap reports the slip.
        send_item(observation(1'b1, 6'd0, t0 + 10_000_000, 1'b1, 1'b1));
        send_item(observation(1'b1, 6'd0, t0, 1'b1, 1'b0));
        send_item(observation(1'b0, 6'd63, '1, 1'b1, 1'b0));
        send_item(observation(1'b0, 6'd63, 30'd604799999, 1'b1, 1'b0));
        send_item(junk_item(gast_pkg::OP_FLUSH));
    endtask

    // Zero, largest and a mid setting of the gap register, each at its edge.
    task automatic test_gap_register;
        logic [29:0] t;
        settle();
        write_gap_limit('0);
        t = 30'd500;
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        t = t + 1;
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        settle();
        write_gap_limit('1);
        t = t + 30'(2047 * 60000);
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        t = t + 30'(2047 * 60000 + 1);
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        settle();
        write_gap_limit(11'd1440);
        t = t + 30'(1440 * 60000 + 1);
        send_item(observation(1'b0, 6'd7, t, 1'b1, 1'b0));
        send_item(junk_item(gast_pkg::OP_FLUSH));
        settle();
        write_gap_limit(gast_pkg::GAP_MIN_RESET);
    endtask

    // Fill every slot in random key order, overflow it, then flush all 64.
    task automatic test_table_full;
        t_sat        ids[$];
        t_sat        s;
        logic [29:0] t;
        int          j;
        send_item(junk_item(gast_pkg::OP_FLUSH));
        for (int i = 0; i < 128; i++) begin
            s.cons = i[6];
            s.prn  = i[5:0];
            ids.insert(ids.size(), s);
        end
        for (int i = 127; i > 0; i--) begin
            j      = $urandom_range(i);
            s      = ids[i];
            ids[i] = ids[j];
            ids[j] = s;
        end
        t = 30'($urandom());
        for (int i = 0; i < gast_pkg::NUM_SLOTS; i++) begin
            send_item(observation(ids[i].cons, ids[i].prn, t, 1'b1, 1'b0));
        end
        for (int i = gast_pkg::NUM_SLOTS; i < gast_pkg::NUM_SLOTS + 3; i++) begin
            send_item(observation(ids[i].cons, ids[i].prn, t, 1'b1,
                                  1'($urandom_range(1))));
        end
        send_item(observation(ids[gast_pkg::NUM_SLOTS + 3].cons,
                              ids[gast_pkg::NUM_SLOTS + 3].prn, t, 1'b0, 1'b0));
        for (int i = 0; i < 4; i++) begin
            send_item(observation(ids[i].cons, ids[i].prn, t + 100, 1'b1, 1'b0));
        end
        send_item(junk_item(gast_pkg::OP_FLUSH));
    endtask

    task automatic test_back_to_back;
        int sent;
        int beats;
        sent = 0;
        settle();
        no_idle = 1'b1;
        while (sent < 40) begin
            run_sky_round(beats);
            sent += beats;
        end
        settle();
        no_idle = 1'b0;
    endtask

    // Mostly well-formed epochs; now and then drain and retune the gap limit.
    task automatic test_random_epochs;
        int sent;
        int beats;
        sent = 0;
        while (sent < 160) begin
            if ($urandom_range(99) < 15) begin
                settle();
                case ($urandom_range(5))
                    0:       write_gap_limit('0);
                    1:       write_gap_limit(11'd1);
                    2:       write_gap_limit(11'd2);
                    3:       write_gap_limit(11'd1440);
                    4:       write_gap_limit('1);
                    default: write_gap_limit(gast_pkg::CFG_W'($urandom_range(2047)));
                endcase
            end
            run_sky_round(beats);
            sent += beats;
        end
    endtask

    initial begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_flush();
        test_arc_basics();
        test_gap_register();
        test_table_full();
        test_back_to_back();
        test_random_epochs();
        // Drain with a bound, then keep the clock running so that stray beats can show.
        in_valid <= 1'b0;
        waited = 0;
        while (arc_reports.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (gast_pkg::NUM_SLOTS + 8) @(posedge clk);
        if (arc_reports.size() != 0) begin
            $error("%0d result beats never arrived", arc_reports.size());
            failures++;
        end
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
